>>> design/eua_pkg.sv
package eua_pkg;

  localparam int unsigned COUNT_BITS = 16;
  localparam int unsigned OUT_BITS   = 32;

  // Correction applied when a counter wraps, and width of the totals.
  localparam logic [63:0] COUNTER_WRAP = 64'd65535;
  localparam int unsigned ACCUM_BITS   = 32;

  localparam logic [COUNT_BITS-1:0] HALF_POINT   = 16'h8000;
  localparam logic [OUT_BITS-1:0]   HOLD_BACKOFF = 32'd100;

  // Signed wheel delta: |count - offset| + wrap, plus a sign bit.
  localparam int unsigned DELTA_BITS = $clog2(COUNTER_WRAP + 64'd65536) + 1;
  localparam int unsigned SUM_BITS   = DELTA_BITS + 1;
  localparam int unsigned WORK_BITS  = (SUM_BITS > ACCUM_BITS) ? SUM_BITS : ACCUM_BITS;
  localparam int unsigned WIDE_BITS  = (ACCUM_BITS > OUT_BITS) ? ACCUM_BITS : OUT_BITS;

  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_CLEAR  = 1'b1;

  typedef struct packed {
    logic                  mode;
    logic [COUNT_BITS-1:0] right_count;
    logic                  right_over;
    logic                  right_under;
    logic [COUNT_BITS-1:0] left_count;
    logic                  left_over;
    logic                  left_under;
  } in_item_t;

  typedef struct packed {
    logic signed [OUT_BITS-1:0] distance_ticks;
    logic signed [OUT_BITS-1:0] angle_ticks;
    logic signed [OUT_BITS-1:0] hold_distance_target;
  } out_item_t;

  // Control for one beat entering the accumulator stage.
  typedef struct packed {
    logic valid;
    logic clear;
  } step_t;

endpackage

>>> design/eua_wheel_delta.sv
module eua_wheel_delta (
  input  logic [eua_pkg::COUNT_BITS-1:0]        count,
  input  logic                                  over,
  input  logic                                  under,
  input  logic [eua_pkg::COUNT_BITS-1:0]        offset,
  output logic signed [eua_pkg::DELTA_BITS-1:0] delta
);

  logic signed [eua_pkg::DELTA_BITS-1:0] base;
  logic signed [eua_pkg::DELTA_BITS-1:0] wrap;
  logic                                  low_half;
  logic                                  add_wrap;
  logic                                  sub_wrap;

  assign base = $signed(eua_pkg::DELTA_BITS'(count)) - $signed(eua_pkg::DELTA_BITS'(offset));
  assign wrap = $signed(eua_pkg::DELTA_BITS'(eua_pkg::COUNTER_WRAP));

  // Both flags set: the reading tells which way the counter wrapped last.
  assign low_half = (count < eua_pkg::HALF_POINT);
  assign add_wrap = over & (~under | low_half);
  assign sub_wrap = under & (~over | ~low_half);

  always_comb begin
    priority if (add_wrap) begin
      delta = base + wrap;
    end else if (sub_wrap) begin
      delta = base - wrap;
    end else begin
      delta = base;
    end
  end

endmodule

>>> design/eua_accum.sv
module eua_accum (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  eua_pkg::step_t                        step,
  input  logic signed [eua_pkg::DELTA_BITS-1:0] delta_right,
  input  logic signed [eua_pkg::DELTA_BITS-1:0] delta_left,
  output logic                                  advance,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output eua_pkg::out_item_t                    out_item
);

  logic [eua_pkg::ACCUM_BITS-1:0] dist_r, dist_nxt;
  logic [eua_pkg::ACCUM_BITS-1:0] angle_r, angle_nxt;
  logic                           out_valid_r, out_valid_nxt;
  eua_pkg::out_item_t             out_item_r, out_item_nxt;

  logic                                  take;
  logic signed [eua_pkg::SUM_BITS-1:0]   sum_w;
  logic signed [eua_pkg::SUM_BITS-1:0]   diff_w;
  logic signed [eua_pkg::SUM_BITS-1:0]   half_w;
  logic signed [eua_pkg::WORK_BITS-1:0]  half_ext;
  logic signed [eua_pkg::WORK_BITS-1:0]  diff_ext;
  logic signed [eua_pkg::WIDE_BITS-1:0]  dist_wide;
  logic signed [eua_pkg::WIDE_BITS-1:0]  angle_wide;

  assign advance = ~out_valid_r | out_ready;
  assign take    = step.valid & advance;

  assign sum_w  = eua_pkg::SUM_BITS'(delta_right) + eua_pkg::SUM_BITS'(delta_left);
  assign diff_w = eua_pkg::SUM_BITS'(delta_right) - eua_pkg::SUM_BITS'(delta_left);
  // Halve toward zero: bias negative sums by one before the shift.
  assign half_w = (sum_w + $signed(eua_pkg::SUM_BITS'(sum_w[eua_pkg::SUM_BITS-1]))) >>> 1;

  assign half_ext = eua_pkg::WORK_BITS'(half_w);
  assign diff_ext = eua_pkg::WORK_BITS'(diff_w);

  always_comb begin
    if (step.clear == eua_pkg::MODE_CLEAR) begin
      dist_nxt  = '0;
      angle_nxt = '0;
    end else begin
      dist_nxt  = dist_r + half_ext[eua_pkg::ACCUM_BITS-1:0];
      angle_nxt = angle_r + diff_ext[eua_pkg::ACCUM_BITS-1:0];
    end
  end

  assign dist_wide  = eua_pkg::WIDE_BITS'($signed(dist_nxt));
  assign angle_wide = eua_pkg::WIDE_BITS'($signed(angle_nxt));

  always_comb begin
    out_item_nxt.distance_ticks       = dist_wide[eua_pkg::OUT_BITS-1:0];
    out_item_nxt.angle_ticks          = angle_wide[eua_pkg::OUT_BITS-1:0];
    out_item_nxt.hold_distance_target =
      dist_wide[eua_pkg::OUT_BITS-1:0] - eua_pkg::HOLD_BACKOFF;
  end

  always_comb begin
    if (take) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dist_r      <= '0;
      angle_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (take) begin
        dist_r  <= dist_nxt;
        angle_r <= angle_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_take_shows: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> out_valid_r)
    else $error("accepted step did not produce a result");

  a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (take && step.clear == eua_pkg::MODE_CLEAR) |=>
      (dist_r == '0 && angle_r == '0 && out_item_r.distance_ticks == '0))
    else $error("clear step left a nonzero total");

  a_hold_offset: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |->
      (out_item_r.hold_distance_target ==
       out_item_r.distance_ticks - eua_pkg::HOLD_BACKOFF))
    else $error("hold target out of step with distance");

  a_totals_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !take |=> ($stable(dist_r) && $stable(angle_r)))
    else $error("totals moved without an accepted step");

endmodule

>>> design/encoder_unwrap_odometry_accumulator.sv
// Differential-drive wheel odometry. Each input beat carries both 16-bit
// encoder counter readings with their overflow and underflow flags; the
// block turns each into a wheel delta (reading minus start_offset, plus or
// minus the counter wrap, with the reading's upper half deciding the
// direction when both flags are set), and keeps two wrapping 32-bit totals:
// angle (right minus left) and distance (half the sum, truncated toward
// zero). Every input beat yields exactly one output beat holding both totals
// after the update and a hold target of distance minus 100. A beat with
// mode set clears both totals (output 0, 0, -100). Throughput is one beat
// per clock while out_ready is high; each beat passes through the input
// register and the result register around the delta and accumulate logic.
// Write start_offset through the cfg_ port only while no beat is in flight;
// cfg_ready is always high.
module encoder_unwrap_odometry_accumulator (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  eua_pkg::in_item_t             in_item,
  output logic                          out_valid,
  input  logic                          out_ready,
  output eua_pkg::out_item_t            out_item,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [eua_pkg::COUNT_BITS-1:0] cfg_data
);

  // Configuration: start offset subtracted from every reading.
  logic [eua_pkg::COUNT_BITS-1:0] offset_r;

  // Input register stage.
  logic                 stage_valid_r, stage_valid_nxt;
  eua_pkg::in_item_t    stage_item_r;

  eua_pkg::step_t                        step;
  logic                                  advance;
  logic signed [eua_pkg::DELTA_BITS-1:0] delta_right;
  logic signed [eua_pkg::DELTA_BITS-1:0] delta_left;

  assign cfg_ready = 1'b1;

  // Take a new beat whenever the stage is empty or moves on this cycle.
  assign in_ready = ~stage_valid_r | advance;

  always_comb begin
    if (in_ready) begin
      stage_valid_nxt = in_valid;
    end else begin
      stage_valid_nxt = stage_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r      <= '0;
      stage_valid_r <= 1'b0;
    end else begin
      stage_valid_r <= stage_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        offset_r <= cfg_data;
      end
    end
  end

  // Hold the payload while stalled; load it on every accepted beat.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_item_r <= in_item;
    end
  end

  eua_wheel_delta u_delta_right (
    .count  (stage_item_r.right_count),
    .over   (stage_item_r.right_over),
    .under  (stage_item_r.right_under),
    .offset (offset_r),
    .delta  (delta_right)
  );

  eua_wheel_delta u_delta_left (
    .count  (stage_item_r.left_count),
    .over   (stage_item_r.left_over),
    .under  (stage_item_r.left_under),
    .offset (offset_r),
    .delta  (delta_left)
  );

  assign step.valid = stage_valid_r;
  assign step.clear = stage_item_r.mode;

  eua_accum u_accum (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step),
    .delta_right (delta_right),
    .delta_left  (delta_left),
    .advance     (advance),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_item    (out_item)
  );

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (stage_valid_r && out_valid && !out_ready))
    else $error("input stalled without a full pipeline");

  a_stage_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> stage_valid_r)
    else $error("accepted beat missing from input stage");

endmodule
